// ----- hw/rtl/tca_pkg.sv -----
package tca_pkg;

  // Field widths
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned CLS_W   = 8;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned LABEL_W = 8;

  // Stream payload widths (fields packed from the lowest bit up)
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT     = 1'd1;

  localparam logic [SCORE_W-1:0] THRESHOLD_RESET   = 16'd0;
  localparam logic [CLS_W-1:0]   CLASS_COUNT_RESET = 8'd19;

  // One per-pixel store entry
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [SCORE_W-1:0] score;
  } entry_t;

endpackage

// ----- hw/rtl/thresholded_class_argmax.sv -----
// Per-pixel thresholded argmax over class score planes. Scores stream in class-major
// order; each transfer carries a pixel index, a class index and an unsigned Q0.16 score.
// The block keeps the best passing score and its label (class + 1, 0 = none) for every
// pixel in a single-port-read / single-port-write memory of PIXELS entries, and emits one
// result when the last class (class_count - 1) of a pixel arrives. Items whose class is
// not below class_count, or whose pixel is not below PIXELS, are taken and dropped.
// Throughput is one item per clock while the result output is not stalled: the memory
// read is issued on the input transfer and the read-modify-write completes in the update
// stage, with a one-entry forward covering a back-to-back hit on the same pixel. Write
// configuration only while the block is idle.
module thresholded_class_argmax #(
  parameter int PIXELS = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [tca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tca_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tca_pkg::IN_DATA_W-1:0]      in_tdata,  // pixel_index, class_index, score
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tca_pkg::OUT_DATA_W-1:0]     out_tdata  // out_pixel_index, class_label,
                                                        // best_score
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // Configuration registers
  logic [tca_pkg::SCORE_W-1:0] threshold_r;
  logic [tca_pkg::CLS_W-1:0]   class_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= tca_pkg::THRESHOLD_RESET;
      class_count_r <= tca_pkg::CLASS_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tca_pkg::CFG_SCORE_THRESHOLD: threshold_r   <= cfg_wdata;
        tca_pkg::CFG_CLASS_COUNT:     class_count_r <= cfg_wdata[tca_pkg::CLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transfer
  logic [tca_pkg::PIX_W-1:0]   in_pix;
  logic [tca_pkg::CLS_W-1:0]   in_cls;
  logic [tca_pkg::SCORE_W-1:0] in_score;
  logic [31:0]                 in_pix_ext;
  logic [AW-1:0]               in_addr;
  logic                        in_fire;
  logic                        in_keep;

  assign in_pix     = in_tdata[15:0];
  assign in_cls     = in_tdata[23:16];
  assign in_score   = in_tdata[39:24];
  assign in_pix_ext = 32'(in_pix);
  assign in_addr    = in_pix_ext[AW-1:0];
  assign in_fire    = in_tvalid && in_tready;
  assign in_keep    = (in_pix_ext < 32'(PIXELS)) && (in_cls < class_count_r);

  // Update stage registers
  logic                        s1_valid_r;
  logic [tca_pkg::PIX_W-1:0]   s1_pix_r;
  logic [AW-1:0]               s1_addr_r;
  logic [tca_pkg::CLS_W-1:0]   s1_cls_r;
  logic [tca_pkg::SCORE_W-1:0] s1_score_r;
  logic                        s1_first_r;
  logic                        s1_last_r;

  // Forward of the write that coincided with this item's memory read
  logic                        fwd_valid_r;
  logic [AW-1:0]               fwd_addr_r;
  tca_pkg::entry_t             fwd_entry_r;

  // Output register
  logic                        out_valid_r;
  logic [tca_pkg::PIX_W-1:0]   out_pix_r;
  tca_pkg::entry_t             out_entry_r;

  // Memory
  tca_pkg::entry_t             mem [PIXELS];
  tca_pkg::entry_t             rd_entry_r;

  logic                        out_free;
  logic                        s1_adv;
  logic                        s1_we;
  tca_pkg::entry_t             prior;
  tca_pkg::entry_t             updated;
  logic                        wins;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign s1_we     = s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  // Pick the prior entry: cleared on the first class, else memory or forward
  always_comb begin
    if (s1_first_r) begin
      prior = '0;
    end else if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      prior = fwd_entry_r;
    end else begin
      prior = rd_entry_r;
    end
    wins = (s1_score_r >= threshold_r) && (s1_score_r > prior.score);
    updated = prior;
    if (wins) begin
      updated.score = s1_score_r;
      updated.label = s1_cls_r + tca_pkg::CLS_W'(1);
    end
  end

  // Read on transfer, write back from the update stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_entry_r <= mem[in_addr];
    end
    if (s1_we) begin
      mem[s1_addr_r] <= updated;
    end
  end

  // Advance the update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r  <= in_keep;
        fwd_valid_r <= s1_we;
      end else if (s1_adv) begin
        s1_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r    <= in_pix;
      s1_addr_r   <= in_addr;
      s1_cls_r    <= in_cls;
      s1_score_r  <= in_score;
      s1_first_r  <= (in_cls == '0);
      s1_last_r   <= ({1'b0, in_cls} + 9'd1) == {1'b0, class_count_r};
      fwd_addr_r  <= s1_addr_r;
      fwd_entry_r <= updated;
    end
  end

  // Hold the result until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_pix_r   <= s1_pix_r;
      out_entry_r <= updated;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_entry_r.score, out_entry_r.label, out_pix_r};

endmodule

// ----- hw/rtl/tca_checker.sv -----
module tca_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tca_pkg::OUT_DATA_W-1:0] out_tdata
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // No label exactly when no score passed
  a_label_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[23:16] == 8'd0) == (out_tdata[39:24] == 16'd0)))
    else $error("label and best score disagree");

  // An empty output slot never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind thresholded_class_argmax tca_checker u_tca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STUCK_LIMIT = 5000;
  localparam int unsigned LONG_HOLD   = 300;

  // Input transfer payload, pixel_index in the lowest bits
  typedef struct packed {
    logic [tca_pkg::SCORE_W-1:0] score;
    logic [tca_pkg::CLS_W-1:0]   class_index;
    logic [tca_pkg::PIX_W-1:0]   pixel_index;
  } score_item_t;

  // Result transfer payload, out_pixel_index in the lowest bits
  typedef struct packed {
    logic [tca_pkg::SCORE_W-1:0] best_score;
    logic [tca_pkg::LABEL_W-1:0] class_label;
    logic [tca_pkg::PIX_W-1:0]   pixel_index;
  } pixel_result_t;

  // Tracks per-pixel winners and holds the pixel decisions still to come
  class argmax_scoreboard;
    logic [tca_pkg::SCORE_W-1:0] kept_score [0:65535];
    logic [tca_pkg::LABEL_W-1:0] kept_label [0:65535];
    logic [tca_pkg::SCORE_W-1:0] threshold;
    logic [tca_pkg::CLS_W-1:0]   class_count;
    pixel_result_t               decisions_q [$];
    int unsigned                 errors;
    int unsigned                 inputs_seen;
    int unsigned                 results_seen;

    function new();
      threshold    = tca_pkg::THRESHOLD_RESET;
      class_count  = tca_pkg::CLASS_COUNT_RESET;
      errors       = 0;
      inputs_seen  = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return decisions_q.size();
    endfunction

    // Update the pixel's winner and queue a decision on its last class
    function void note_input(score_item_t it);
      logic [tca_pkg::SCORE_W-1:0] best;
      logic [tca_pkg::LABEL_W-1:0] label;
      pixel_result_t               decision;
      inputs_seen++;
      if (it.class_index >= class_count) return;
      if (it.class_index == '0) begin
        best  = '0;
        label = '0;
      end else begin
        best  = kept_score[it.pixel_index];
        label = kept_label[it.pixel_index];
      end
      if (it.score >= threshold && it.score > best) begin
        best  = it.score;
        label = tca_pkg::LABEL_W'(it.class_index + 1);
      end
      kept_score[it.pixel_index] = best;
      kept_label[it.pixel_index] = label;
      if (32'(it.class_index) + 1 == 32'(class_count)) begin
        decision.pixel_index = it.pixel_index;
        decision.class_label = label;
        decision.best_score  = best;
        decisions_q.push_back(decision);
      end
    endfunction

    task report(string msg);
      if (errors < 50) $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compare one result transfer with the oldest queued decision
    task check_result(logic [tca_pkg::OUT_DATA_W-1:0] data);
      pixel_result_t got;
      pixel_result_t want;
      got = data;
      results_seen++;
      if (decisions_q.size() == 0) begin
        report($sformatf("result for pixel %0d with nothing queued", got.pixel_index));
        return;
      end
      want = decisions_q.pop_front();
      if (got.pixel_index !== want.pixel_index)
        report($sformatf("pixel_index got %0d want %0d", got.pixel_index, want.pixel_index));
      if (got.class_label !== want.class_label)
        report($sformatf("pixel %0d class_label got %0d want %0d",
                         want.pixel_index, got.class_label, want.class_label));
      if (got.best_score !== want.best_score)
        report($sformatf("pixel %0d best_score got %h want %h",
                         want.pixel_index, got.best_score, want.best_score));
    endtask
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [tca_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tca_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [tca_pkg::IN_DATA_W-1:0]  in_tdata;   // pixel_index, class_index, score
  logic                           out_tvalid;
  logic                           out_tready;
  logic [tca_pkg::OUT_DATA_W-1:0] out_tdata;  // out_pixel_index, class_label, best_score

  argmax_scoreboard            sb;
  bit                          quiet;
  bit                          hold_req;
  int unsigned                 items_sent;
  int unsigned                 settings_run;
  int unsigned                 stuck_cycles;
  logic [tca_pkg::SCORE_W-1:0] cur_thr;
  int unsigned                 cur_cc;
  bit                          pixel_written [0:65535];
  logic [tca_pkg::PIX_W-1:0]   written_list [$];

  thresholded_class_argmax #(.PIXELS(65536)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Pick a fresh pixel, or now and then one that was already written
  function automatic logic [tca_pkg::PIX_W-1:0] pick_pixel();
    if (written_list.size() > 0 && $urandom_range(0, 2) == 0)
      return written_list[$urandom_range(0, written_list.size() - 1)];
    return tca_pkg::PIX_W'($urandom_range(0, 65535));
  endfunction

  // Bias scores toward the threshold edges and ties with the kept best
  function automatic logic [tca_pkg::SCORE_W-1:0] pick_score(
    logic [tca_pkg::PIX_W-1:0] pix, int unsigned cls);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return cur_thr;
      3:       return cur_thr - 1'b1;
      4:       return cur_thr + 1'b1;
      5:       return (cls > 0) ? sb.kept_score[pix] : cur_thr;
      default: return tca_pkg::SCORE_W'($urandom());
    endcase
  endfunction

  // Offer one score item and hold it until the transfer
  task automatic send_item(logic [tca_pkg::PIX_W-1:0] pix, logic [tca_pkg::CLS_W-1:0] cls,
                           logic [tca_pkg::SCORE_W-1:0] sc);
    score_item_t it;
    it.pixel_index = pix;
    it.class_index = cls;
    it.score       = sc;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(it);
    items_sent++;
    if (cls < cur_cc && !pixel_written[pix]) begin
      pixel_written[pix] = 1'b1;
      written_list.push_back(pix);
    end
  endtask

  // Class-major frame over a few pixels, classes 0 to ncls-1
  task automatic send_frame(int unsigned npix, int unsigned ncls);
    logic [tca_pkg::PIX_W-1:0] pix [4];
    for (int unsigned p = 0; p < npix; p++) pix[p] = pick_pixel();
    for (int unsigned c = 0; c < ncls; c++)
      for (int unsigned p = 0; p < npix; p++)
        send_item(pix[p], tca_pkg::CLS_W'(c), pick_score(pix[p], c));
  endtask

  // Mostly whole frames, plus cut-off frames, ignored classes and stray items
  task automatic run_random(int unsigned budget);
    int unsigned stop;
    int unsigned n;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        7: begin
          if (cur_cc > 1) send_frame($urandom_range(1, 3), $urandom_range(1, cur_cc - 1));
        end
        8: begin
          if (cur_cc <= 254 && written_list.size() > 0) begin
            n = $urandom_range(1, 3);
            repeat (n) send_item(pick_pixel() & '0 | written_list[$urandom_range(0,
                                 written_list.size() - 1)],
                                 tca_pkg::CLS_W'($urandom_range(cur_cc, 254)),
                                 tca_pkg::SCORE_W'($urandom()));
          end
        end
        9: begin
          if (cur_cc > 1 && written_list.size() > 0) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
              logic [tca_pkg::PIX_W-1:0] pix;
              int unsigned               cls;
              pix = written_list[$urandom_range(0, written_list.size() - 1)];
              cls = $urandom_range(1, cur_cc - 1);
              send_item(pix, tca_pkg::CLS_W'(cls), pick_score(pix, cls));
            end
          end
        end
        default: send_frame($urandom_range(1, 3), cur_cc);
      endcase
    end
  endtask

  // Drop valid, wait out every queued decision and the pipeline tail
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles while idle
  task automatic set_config(logic [tca_pkg::SCORE_W-1:0] thr, logic [tca_pkg::CLS_W-1:0] cc);
    cfg_we    <= 1'b1;
    cfg_index <= tca_pkg::CFG_SCORE_THRESHOLD;
    cfg_wdata <= tca_pkg::CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_index <= tca_pkg::CFG_CLASS_COUNT;
    cfg_wdata <= tca_pkg::CFG_DATA_W'(cc);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.threshold   = thr;
    sb.class_count = cc;
    cur_thr        = thr;
    cur_cc         = cc;
    settings_run++;
  endtask

  // Main sequence
  initial begin
    sb           = new();
    quiet        = 1'b0;
    hold_req     = 1'b0;
    items_sent   = 0;
    settings_run = 1;
    cur_thr      = tca_pkg::THRESHOLD_RESET;
    cur_cc       = tca_pkg::CLASS_COUNT_RESET;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= tca_pkg::CFG_SCORE_THRESHOLD;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero score never wins, ties lose, ignored classes leave state alone
    send_item(16'hFFFF, 8'd0, 16'h0000);
    send_item(16'hFFFF, 8'd1, 16'h1234);
    send_item(16'hFFFF, 8'd2, 16'h1234);
    send_item(16'hFFFF, 8'd3, 16'h1233);
    send_item(16'hFFFF, 8'd19, 16'h5000);
    send_item(16'hFFFF, 8'd254, 16'h6000);
    send_item(16'hFFFF, 8'd4, 16'hFFFF);
    send_item(16'hFFFF, 8'd5, 16'hFFFF);
    for (int unsigned c = 6; c < 19; c++)
      send_item(16'hFFFF, tca_pkg::CLS_W'(c),
                tca_pkg::SCORE_W'($urandom_range(0, 16'hFFFE)));
    drain();

    // One class per frame, receiver holds off long enough to stall the input
    set_config(16'h0000, 8'd1);
    hold_req = 1'b1;
    send_item(16'h0000, 8'd0, 16'h0000);
    send_item(16'h0000, 8'd0, 16'hFFFF);
    run_random(100);
    drain();

    // Highest threshold: only full-scale scores can win
    set_config(16'hFFFF, 8'd3);
    run_random(60);
    drain();

    set_config(16'h8000, 8'd5);
    run_random(100);
    drain();

    // Largest class count, one pixel
    set_config(tca_pkg::SCORE_W'($urandom()), 8'd255);
    send_frame(1, 255);
    drain();

    set_config(tca_pkg::SCORE_W'($urandom()), tca_pkg::CLS_W'($urandom_range(2, 8)));
    run_random(100);
    drain();

    // Final stretch with both sides always ready
    quiet = 1'b1;
    set_config(tca_pkg::SCORE_W'($urandom()), tca_pkg::CLS_W'($urandom_range(2, 12)));
    run_random(100);
    drain();

    $display("Sent %0d score items over %0d register settings; %0d pixel decisions checked",
             sb.inputs_seen, settings_run, sb.results_seen);
    $display("Thresholds 0 to full scale, 1 to 255 classes, stalls and gaps on both channels");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result receiver: random stalls, one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) sb.check_result(out_tdata);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  initial begin
    stuck_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid === 1'b1 && in_tready === 1'b1) ||
          (out_tvalid === 1'b1 && out_tready === 1'b1)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer", stuck_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
